@@ sv/mrh_pkg.sv @@
// shared constants, codes and transfer types for the serial link channel hub
package mrh_pkg;

  localparam int CHANNELS        = 16;
  localparam int RX_RING_BYTES   = 64;
  localparam int TX_BUFFER_BYTES = 64;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int RX_W   = $clog2(RX_RING_BYTES);
  localparam int FILL_W = $clog2(TX_BUFFER_BYTES);
  // wide enough for fill plus a whole message length, and for channel compares
  localparam int CMP_W  = 9;

  localparam logic [2:0] OP_REGISTER  = 3'd0;
  localparam logic [2:0] OP_RX_BYTE   = 3'd1;
  localparam logic [2:0] OP_READ      = 3'd2;
  localparam logic [2:0] OP_QUERY     = 3'd3;
  localparam logic [2:0] OP_TX_APPEND = 3'd4;
  localparam logic [2:0] OP_TX_DONE   = 3'd5;
  localparam logic [2:0] OP_POLL      = 3'd6;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_CHANNEL = 3'd1;
  localparam logic [2:0] ST_LINK_BUSY  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG   = 3'd3;
  localparam logic [2:0] ST_NOTHING    = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] channel;
    logic [7:0] data_byte;
    logic [7:0] message_length;
    logic       first_of_message;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] channel_id;
    logic [7:0] byte_out;
    logic       is_empty;
    logic       is_last;
  } res_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic ring_out;
    logic drain_issue;
    logic drain_send;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       drain_go;
    logic       drain_last;
  } sts_t;

endpackage

@@ sv/multi_reader_rx_ring_and_tx_channel_hub.sv @@
// top level of the serial link channel hub: state machine plus datapath
//
//   channel   ports                   transfer
//   -------   ---------------------   ------------------------------------
//   request   start, busy, request    start high and busy low at the edge
//   result    strobe, result          strobe high for one cycle, always taken
//
// most opcodes pass through the exec state and back to idle; the result strobe
// is high in the first cycle with busy low again. a read adds a ring state for
// the registered rx ring read port. a poll that drains bytes alternates a drain
// read and a drain send state per byte, through the tx staging memory read.
// reset clears rx ring entries through per-entry valid bits, so no clearing pass.
// the result side cannot stall; nothing here waits on it.
module multi_reader_rx_ring_and_tx_channel_hub (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mrh_pkg::req_t request,
  output logic          busy,
  output logic          strobe,
  output mrh_pkg::res_t result
);

  mrh_pkg::cmd_t cmd;
  mrh_pkg::sts_t sts;

  mrh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  mrh_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .strobe  (strobe)
  );

endmodule

@@ sv/mrh_ctrl.sv @@
// sequencing state machine for the channel hub
module mrh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mrh_pkg::sts_t sts,
  output mrh_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_RING     = 3'd2;
  localparam logic [2:0] S_DRAIN_RD = 3'd3;
  localparam logic [2:0] S_DRAIN_TX = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.op == mrh_pkg::OP_READ) begin
          state_next = S_RING;
        end else if (sts.op == mrh_pkg::OP_POLL && sts.drain_go) begin
          state_next = S_DRAIN_RD;
        end else begin
          // unused opcodes give no result
          cmd.emit   = (sts.op <= mrh_pkg::OP_POLL);
          state_next = S_IDLE;
        end
      end
      S_RING: begin
        cmd.ring_out = 1'b1;
        cmd.emit     = 1'b1;
        state_next   = S_IDLE;
      end
      S_DRAIN_RD: begin
        cmd.drain_issue = 1'b1;
        state_next      = S_DRAIN_TX;
      end
      S_DRAIN_TX: begin
        cmd.drain_send = 1'b1;
        cmd.emit       = 1'b1;
        state_next     = sts.drain_last ? S_IDLE : S_DRAIN_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/mrh_dp.sv @@
// channel hub datapath: rx ring, read cursors, tx staging buffers and result register
module mrh_dp (
  input  logic          clk,
  input  logic          rst,
  input  mrh_pkg::req_t request,
  input  mrh_pkg::cmd_t cmd,
  output mrh_pkg::sts_t sts,
  output mrh_pkg::res_t result,
  output logic          strobe
);

  mrh_pkg::req_t req;

  logic [mrh_pkg::CNT_W-1:0]  registered_count;
  logic [mrh_pkg::RX_W-1:0]   rx_write_index;
  logic [mrh_pkg::RX_W-1:0]   read_cursor [mrh_pkg::CHANNELS];
  logic [mrh_pkg::FILL_W-1:0] tx_fill [mrh_pkg::CHANNELS];
  logic                       link_busy;
  logic                       message_rejected;
  logic [mrh_pkg::RX_RING_BYTES-1:0] ring_valid;

  logic [7:0] rx_ring [mrh_pkg::RX_RING_BYTES];
  logic [7:0] tx_store [mrh_pkg::CHANNELS][mrh_pkg::TX_BUFFER_BYTES];

  logic [7:0] ring_rd;
  logic       ring_rd_valid;
  logic       rd_empty;
  logic       rd_ok;
  logic [7:0] tx_rd;

  logic [mrh_pkg::CH_W-1:0]   drain_ch;
  logic [mrh_pkg::FILL_W-1:0] drain_n;
  logic [mrh_pkg::FILL_W-1:0] drain_idx;

  logic                       ch_ok;
  logic [mrh_pkg::CH_W-1:0]   ch_idx;
  logic [mrh_pkg::RX_W-1:0]   cur;
  logic [mrh_pkg::RX_W-1:0]   cur_inc;
  logic [mrh_pkg::RX_W-1:0]   widx_inc;
  logic [mrh_pkg::FILL_W-1:0] fill_sel;
  logic [mrh_pkg::CMP_W-1:0]  fill_wide;
  logic [mrh_pkg::CMP_W-1:0]  len_wide;
  logic [2:0]                 app_status;
  logic                       app_store;
  logic                       app_rej_next;
  logic                       found;
  logic [mrh_pkg::CH_W-1:0]   sel_ch;
  logic                       drain_go;
  logic                       drain_last;
  logic                       reg_full;
  mrh_pkg::res_t              exec_res;
  mrh_pkg::res_t              ring_res;
  mrh_pkg::res_t              drain_res;

  assign ch_ok     = (mrh_pkg::CMP_W'(req.channel) < mrh_pkg::CMP_W'(mrh_pkg::CHANNELS));
  assign ch_idx    = mrh_pkg::CH_W'(req.channel);
  assign cur       = read_cursor[ch_idx];
  assign fill_sel  = tx_fill[ch_idx];
  assign cur_inc   = (cur == mrh_pkg::RX_W'(mrh_pkg::RX_RING_BYTES - 1)) ? '0 : cur + 1'b1;
  assign widx_inc  = (rx_write_index == mrh_pkg::RX_W'(mrh_pkg::RX_RING_BYTES - 1)) ?
                     '0 : rx_write_index + 1'b1;
  assign fill_wide = mrh_pkg::CMP_W'(fill_sel);
  assign len_wide  = mrh_pkg::CMP_W'(req.message_length);
  assign reg_full  = (registered_count >= mrh_pkg::CNT_W'(mrh_pkg::CHANNELS));

  // admission check on the first byte, run checks on the rest
  always_comb begin
    app_status   = mrh_pkg::ST_OK;
    app_store    = 1'b0;
    app_rej_next = message_rejected;
    if (!ch_ok) begin
      app_status = mrh_pkg::ST_NO_CHANNEL;
    end else if (req.first_of_message) begin
      if (link_busy) begin
        app_status   = mrh_pkg::ST_LINK_BUSY;
        app_rej_next = 1'b1;
      end else if (len_wide > mrh_pkg::CMP_W'(mrh_pkg::TX_BUFFER_BYTES) ||
                   fill_wide + len_wide >= mrh_pkg::CMP_W'(mrh_pkg::TX_BUFFER_BYTES)) begin
        app_status   = mrh_pkg::ST_TOO_LONG;
        app_rej_next = 1'b1;
      end else if (req.message_length == 8'd0) begin
        // empty message: admitted, but stray bytes after it are dropped
        app_rej_next = 1'b1;
      end else begin
        app_rej_next = 1'b0;
        app_store    = 1'b1;
      end
    end else begin
      if (message_rejected) begin
        app_status = mrh_pkg::ST_TOO_LONG;
      end else if (fill_wide + 1'b1 >= mrh_pkg::CMP_W'(mrh_pkg::TX_BUFFER_BYTES)) begin
        app_status   = mrh_pkg::ST_TOO_LONG;
        app_rej_next = 1'b1;
      end else begin
        app_store = 1'b1;
      end
    end
  end

  // lowest-numbered channel with staged bytes
  always_comb begin
    found  = 1'b0;
    sel_ch = '0;
    for (int i = mrh_pkg::CHANNELS - 1; i >= 0; i--) begin
      if (tx_fill[mrh_pkg::CH_W'(i)] != '0) begin
        found  = 1'b1;
        sel_ch = mrh_pkg::CH_W'(i);
      end
    end
  end

  assign drain_go   = !link_busy && found;
  assign drain_last = (drain_idx + mrh_pkg::FILL_W'(1) == drain_n);

  assign sts.op         = req.opcode;
  assign sts.drain_go   = drain_go;
  assign sts.drain_last = drain_last;

  always_comb begin
    exec_res         = '0;
    exec_res.is_last = 1'b1;
    unique case (req.opcode)
      mrh_pkg::OP_REGISTER: begin
        if (reg_full) begin
          exec_res.status = mrh_pkg::ST_NO_CHANNEL;
        end else begin
          exec_res.channel_id = 4'(registered_count);
        end
      end
      mrh_pkg::OP_QUERY: begin
        exec_res.is_empty = ch_ok ? (cur == rx_write_index) : 1'b1;
      end
      mrh_pkg::OP_TX_APPEND: begin
        exec_res.status = app_status;
      end
      mrh_pkg::OP_POLL: begin
        exec_res.status = link_busy ? mrh_pkg::ST_LINK_BUSY : mrh_pkg::ST_NOTHING;
      end
      default: begin
        exec_res.status = mrh_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    ring_res          = '0;
    ring_res.byte_out = (rd_ok && ring_rd_valid) ? ring_rd : 8'd0;
    ring_res.is_empty = rd_ok ? rd_empty : 1'b1;
    ring_res.is_last  = 1'b1;
  end

  always_comb begin
    drain_res            = '0;
    drain_res.channel_id = 4'(drain_ch);
    drain_res.byte_out   = tx_rd;
    drain_res.is_last    = drain_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      registered_count <= '0;
      rx_write_index   <= '0;
      link_busy        <= 1'b0;
      message_rejected <= 1'b0;
      ring_valid       <= '0;
      drain_ch         <= '0;
      drain_n          <= '0;
      drain_idx        <= '0;
      strobe           <= 1'b0;
      for (int i = 0; i < mrh_pkg::CHANNELS; i++) begin
        read_cursor[mrh_pkg::CH_W'(i)] <= '0;
        tx_fill[mrh_pkg::CH_W'(i)]     <= '0;
      end
    end else begin
      strobe <= cmd.emit;
      if (cmd.exec) begin
        unique case (req.opcode)
          mrh_pkg::OP_REGISTER: begin
            if (!reg_full) begin
              registered_count <= registered_count + 1'b1;
            end
          end
          mrh_pkg::OP_RX_BYTE: begin
            ring_valid[rx_write_index] <= 1'b1;
            rx_write_index             <= widx_inc;
          end
          mrh_pkg::OP_READ: begin
            // cursor moves even when the channel is empty
            if (ch_ok) begin
              read_cursor[ch_idx] <= cur_inc;
            end
          end
          mrh_pkg::OP_TX_APPEND: begin
            if (ch_ok) begin
              message_rejected <= app_rej_next;
            end
            if (app_store) begin
              tx_fill[ch_idx] <= fill_sel + 1'b1;
            end
          end
          mrh_pkg::OP_TX_DONE: begin
            link_busy <= 1'b0;
          end
          mrh_pkg::OP_POLL: begin
            if (drain_go) begin
              drain_ch  <= sel_ch;
              drain_n   <= tx_fill[sel_ch];
              drain_idx <= '0;
            end
          end
          default: begin
            link_busy <= link_busy;
          end
        endcase
      end
      if (cmd.drain_send) begin
        drain_idx <= drain_idx + 1'b1;
        if (drain_last) begin
          tx_fill[drain_ch] <= '0;
          link_busy         <= 1'b1;
        end
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= request;
    end
    if (cmd.exec && req.opcode == mrh_pkg::OP_RX_BYTE) begin
      rx_ring[rx_write_index] <= req.data_byte;
    end
    if (cmd.exec && req.opcode == mrh_pkg::OP_READ) begin
      ring_rd       <= rx_ring[cur];
      ring_rd_valid <= ring_valid[cur];
      rd_empty      <= (cur == rx_write_index);
      rd_ok         <= ch_ok;
    end
    if (cmd.exec && req.opcode == mrh_pkg::OP_TX_APPEND && app_store) begin
      tx_store[ch_idx][fill_sel] <= req.data_byte;
    end
    if (cmd.drain_issue) begin
      tx_rd <= tx_store[drain_ch][drain_idx];
    end
    if (cmd.emit) begin
      if (cmd.drain_send) begin
        result <= drain_res;
      end else if (cmd.ring_out) begin
        result <= ring_res;
      end else begin
        result <= exec_res;
      end
    end
  end

`ifndef SYNTH
  a_drain_end_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.drain_send && drain_last) |=> (link_busy && tx_fill[$past(drain_ch)] == '0))
    else $error("drain end did not clear fill and mark link busy");

  a_drain_start_clean: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.opcode == mrh_pkg::OP_POLL && drain_go) |=>
    (drain_idx == '0 && drain_n != '0 && !link_busy))
    else $error("drain started with bad count or busy link");

  a_rx_write_advances: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.opcode == mrh_pkg::OP_RX_BYTE) |=>
    (ring_valid[$past(rx_write_index)] && rx_write_index != $past(rx_write_index)))
    else $error("rx byte write did not mark the entry or advance the index");
`endif

endmodule

@@ tb/hub_checker.sv @@
`timescale 1ns / 100ps
// checker for the channel hub: predicts the results of every request transfer and compares
module hub_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  mrh_pkg::req_t request,
  input  logic          strobe,
  input  mrh_pkg::res_t result,
  output int            errors,
  output int            pending
);

  int            reg_count;
  logic [7:0]    ring [mrh_pkg::RX_RING_BYTES];
  int            wr_idx;
  int            cursor [mrh_pkg::CHANNELS];
  logic [7:0]    tx_mem [mrh_pkg::CHANNELS][mrh_pkg::TX_BUFFER_BYTES];
  int            fill [mrh_pkg::CHANNELS];
  logic          link_busy;
  logic          msg_rejected;
  mrh_pkg::res_t due_results [$];
  int            mismatches = 0;

  // works out the results one accepted request causes and queues them
  task automatic step_hub(input mrh_pkg::req_t r);
    mrh_pkg::res_t            o;
    int                       ch, len, sel, c, i;
    logic [mrh_pkg::CH_W-1:0] chi;
    logic [mrh_pkg::CH_W-1:0] selch;
    logic                     emit, store;
    ch = int'(r.channel);
    chi = mrh_pkg::CH_W'(r.channel);
    len = int'(r.message_length);
    selch = '0;
    o = '0;
    o.is_last = 1'b1;
    emit = 1'b1;
    store = 1'b0;
    case (r.opcode) inside
      mrh_pkg::OP_REGISTER: begin
        if (reg_count >= mrh_pkg::CHANNELS) begin
          o.status = mrh_pkg::ST_NO_CHANNEL;
        end else begin
          o.channel_id = 4'(reg_count);
          reg_count++;
        end
      end
      mrh_pkg::OP_RX_BYTE: begin
        ring[mrh_pkg::RX_W'(wr_idx)] = r.data_byte;
        wr_idx = (wr_idx + 1) % mrh_pkg::RX_RING_BYTES;
      end
      mrh_pkg::OP_READ, mrh_pkg::OP_QUERY: begin
        o.is_empty = 1'b1;
        if (ch < mrh_pkg::CHANNELS) begin
          o.is_empty = (cursor[chi] == wr_idx);
          // an empty read still hands out the stale byte and moves on
          if (r.opcode == mrh_pkg::OP_READ) begin
            o.byte_out = ring[mrh_pkg::RX_W'(cursor[chi])];
            cursor[chi] = (cursor[chi] + 1) % mrh_pkg::RX_RING_BYTES;
          end
        end
      end
      mrh_pkg::OP_TX_APPEND: begin
        if (ch >= mrh_pkg::CHANNELS) begin
          o.status = mrh_pkg::ST_NO_CHANNEL;
        end else if (r.first_of_message) begin
          if (link_busy) begin
            msg_rejected = 1'b1;
            o.status = mrh_pkg::ST_LINK_BUSY;
          end else if (len > mrh_pkg::TX_BUFFER_BYTES ||
                       fill[chi] + len >= mrh_pkg::TX_BUFFER_BYTES) begin
            msg_rejected = 1'b1;
            o.status = mrh_pkg::ST_TOO_LONG;
          end else if (len == 0) begin
            // empty message: accepted, but stray bytes after it are dropped
            msg_rejected = 1'b1;
          end else begin
            msg_rejected = 1'b0;
            store = 1'b1;
          end
        end else if (msg_rejected) begin
          o.status = mrh_pkg::ST_TOO_LONG;
        end else if (fill[chi] + 1 >= mrh_pkg::TX_BUFFER_BYTES) begin
          msg_rejected = 1'b1;
          o.status = mrh_pkg::ST_TOO_LONG;
        end else begin
          store = 1'b1;
        end
        if (store) begin
          tx_mem[chi][mrh_pkg::FILL_W'(fill[chi])] = r.data_byte;
          fill[chi]++;
        end
      end
      mrh_pkg::OP_TX_DONE: link_busy = 1'b0;
      mrh_pkg::OP_POLL: begin
        if (link_busy) begin
          o.status = mrh_pkg::ST_LINK_BUSY;
        end else begin
          sel = -1;
          for (c = mrh_pkg::CHANNELS - 1; c >= 0; c--) begin
            if (fill[mrh_pkg::CH_W'(c)] != 0) sel = c;
          end
          if (sel < 0) begin
            o.status = mrh_pkg::ST_NOTHING;
          end else begin
            emit = 1'b0;
            selch = mrh_pkg::CH_W'(sel);
            for (i = 0; i < fill[selch]; i++) begin
              o.channel_id = 4'(sel);
              o.byte_out = tx_mem[selch][mrh_pkg::FILL_W'(i)];
              o.is_last = (i == fill[selch] - 1);
              due_results.push_back(o);
            end
            fill[selch] = 0;
            link_busy = 1'b1;
          end
        end
      end
      default: emit = 1'b0;
    endcase
    if (emit) due_results.push_back(o);
  endtask

  always @(posedge clk) begin : watch
    mrh_pkg::res_t want;
    if (rst) begin
      reg_count = 0;
      wr_idx = 0;
      link_busy = 1'b0;
      msg_rejected = 1'b0;
      foreach (ring[i]) ring[i] = '0;
      foreach (cursor[i]) begin
        cursor[i] = 0;
        fill[i] = 0;
      end
      due_results.delete();
    end else begin
      // results first, so a transfer accepted at this edge queues behind them
      if (strobe) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: %p", result);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, result.status);
            mismatches++;
          end
          if (result.channel_id !== want.channel_id) begin
            $error("channel_id expected %0d actual %0d", want.channel_id, result.channel_id);
            mismatches++;
          end
          if (result.byte_out !== want.byte_out) begin
            $error("byte_out expected %0h actual %0h", want.byte_out, result.byte_out);
            mismatches++;
          end
          if (result.is_empty !== want.is_empty) begin
            $error("is_empty expected %0b actual %0b", want.is_empty, result.is_empty);
            mismatches++;
          end
          if (result.is_last !== want.is_last) begin
            $error("is_last expected %0b actual %0b", want.is_last, result.is_last);
            mismatches++;
          end
        end
      end
      if (start && !busy) step_hub(request);
    end
    errors <= mismatches;
    pending <= due_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// testbench top for the channel hub: clock, reset, request stimulus and verdict
module tb;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int ITEMS = 320;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  mrh_pkg::req_t request = '0;
  logic          busy;
  logic          strobe;
  mrh_pkg::res_t result;
  int            errors;
  int            pending;
  int            items_sent = 0;
  int            idle_cycles = 0;
  bit            no_gaps = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_reader_rx_ring_and_tx_channel_hub u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
  );

  hub_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .strobe  (strobe),
    .result  (result),
    .errors  (errors),
    .pending (pending)
  );

  function automatic mrh_pkg::req_t make_req(logic [2:0] op, int ch, int data, int len,
                                             int first);
    mrh_pkg::req_t r;
    r.opcode = op;
    r.channel = 4'(ch);
    r.data_byte = 8'(data);
    r.message_length = 8'(len);
    r.first_of_message = 1'(first);
    return r;
  endfunction

  function automatic int pick_channel();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
  endfunction

  // one request transfer, after a random idle gap unless no_gaps is set
  task automatic issue(input mrh_pkg::req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (r.opcode != OP_UNUSED) items_sent++;
  endtask

  task automatic send_message(int ch, int len, int nbytes);
    int k;
    for (k = 0; k < nbytes; k++) begin
      issue(make_req(mrh_pkg::OP_TX_APPEND, ch, $urandom_range(0, 255),
                     (k == 0) ? len : $urandom_range(0, 255), int'(k == 0)));
    end
  endtask

  // no transfer on either side for too long means the block hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("multi_reader_rx_ring_and_tx_channel_hub verification failed");
      $finish;
    end
  end

  initial begin
    int len, nbytes, ch;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue(make_req(mrh_pkg::OP_QUERY, 15, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_READ, 15, 0, 0, 0));   // empty read moves the cursor anyway
    issue(make_req(mrh_pkg::OP_REGISTER, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_RX_BYTE, 0, 255, 0, 0));
    issue(make_req(mrh_pkg::OP_RX_BYTE, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_READ, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_QUERY, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_POLL, 0, 0, 0, 0));    // nothing staged yet
    issue(make_req(mrh_pkg::OP_TX_APPEND, 3, 'h5a, 0, 1));  // empty message
    issue(make_req(mrh_pkg::OP_TX_APPEND, 3, 'ha5, 0, 0));  // stray byte after it
    issue(make_req(mrh_pkg::OP_TX_APPEND, 0, 1, 255, 1));
    issue(make_req(mrh_pkg::OP_TX_APPEND, 0, 1, mrh_pkg::TX_BUFFER_BYTES, 1));
    send_message(0, 2, 2);
    send_message(15, 1, 1);
    issue(make_req(mrh_pkg::OP_POLL, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_POLL, 0, 0, 0, 0));    // link still busy
    issue(make_req(mrh_pkg::OP_TX_APPEND, 1, 'h11, 1, 1));
    issue(make_req(mrh_pkg::OP_TX_APPEND, 1, 'h22, 0, 0));
    issue(make_req(OP_UNUSED, 15, 255, 255, 1));
    issue(make_req(mrh_pkg::OP_TX_DONE, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_POLL, 0, 0, 0, 0));
    issue(make_req(mrh_pkg::OP_TX_DONE, 0, 0, 0, 0));

    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
      case ($urandom_range(0, 10))
        0, 1, 2: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
          // now and then a message with too few or too many bytes
          nbytes = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len + 3) : len;
          send_message(pick_channel(), len, nbytes);
        end
        3: repeat ($urandom_range(1, 6)) begin
          issue(make_req(mrh_pkg::OP_RX_BYTE, $urandom_range(0, 15), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 1)));
        end
        4: begin
          ch = pick_channel();
          repeat ($urandom_range(1, 4)) begin
            issue(make_req($urandom_range(0, 1) ? mrh_pkg::OP_READ : mrh_pkg::OP_QUERY, ch,
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 1)));
          end
        end
        5: begin
          issue(make_req(mrh_pkg::OP_POLL, 0, 0, 0, 0));
          if ($urandom_range(0, 3) != 0) issue(make_req(mrh_pkg::OP_TX_DONE, 0, 0, 0, 0));
        end
        6: repeat ($urandom_range(1, 4)) issue(make_req(mrh_pkg::OP_REGISTER, 0, 0, 0, 0));
        7: issue(make_req(mrh_pkg::OP_TX_DONE, 0, 0, 0, 0));
        default: begin
          issue(make_req(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 1)));
        end
      endcase
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("multi_reader_rx_ring_and_tx_channel_hub verification clean");
    end else begin
      $display("multi_reader_rx_ring_and_tx_channel_hub verification failed");
    end
    $finish;
  end

endmodule
